// ===== rtl/core/look_at_view_matrix_defines.svh =====
// assertion macros shared by the look-at view matrix rtl
// expects clk and rst_n in the scope where a macro is used
`ifndef LOOK_AT_VIEW_MATRIX_DEFINES_SVH
`define LOOK_AT_VIEW_MATRIX_DEFINES_SVH

// same-cycle implication, checked out of reset
`define LAV_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define LAV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/lav_pkg.sv =====
// shared widths, types and row codes of the look-at view matrix block
// no dependencies
package lav_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DW  = 32;                 // field width
  localparam int UW  = FRAC_BITS + 2;      // unit axis component, signed
  localparam int VW  = FRAC_BITS + 34;     // vector into the normalizer, signed
  localparam int MW  = VW - 1;             // magnitude width
  localparam int NSH = $clog2(MW);         // alignment shift stages
  localparam int NB  = 30;                 // aligned magnitude width
  localparam int QB  = FRAC_BITS + 1;      // quotient bits

  localparam logic [1:0] ROW_S = 2'd0;
  localparam logic [1:0] ROW_U = 2'd1;
  localparam logic [1:0] ROW_F = 2'd2;
  localparam logic [1:0] ROW_W = 2'd3;

  localparam logic signed [DW-1:0] ONE_Q = DW'(1 << FRAC_BITS);

  typedef logic signed [DW-1:0] word_t;
  typedef logic signed [UW-1:0] unit_t;
  typedef logic signed [UW:0]   uwide_t;
  typedef logic signed [VW-1:0] vec_t;

  typedef struct packed {
    word_t [2:0] eye;
    word_t [2:0] up;
    unit_t [2:0] f;
    logic        ok;
  } side_t;

  typedef struct packed {
    unit_t  [2:0] s;
    uwide_t [2:0] u;
    unit_t  [2:0] f;
    word_t  [2:0] t;
    logic         ok;
  } mat_t;

endpackage

// ===== rtl/core/lav_if.sv =====
// valid/ready channel interfaces for camera requests and matrix rows
// depends on lav_pkg
interface lav_in_if;
  import lav_pkg::*;
  logic  valid;
  logic  ready;
  word_t eye_x;
  word_t eye_y;
  word_t eye_z;
  word_t target_x;
  word_t target_y;
  word_t target_z;
  word_t up_x;
  word_t up_y;
  word_t up_z;
  modport source (output valid, eye_x, eye_y, eye_z, target_x, target_y, target_z,
                  up_x, up_y, up_z, input ready);
  modport sink (input valid, eye_x, eye_y, eye_z, target_x, target_y, target_z,
                up_x, up_y, up_z, output ready);
endinterface

interface lav_out_if;
  import lav_pkg::*;
  logic       valid;
  logic       ready;
  logic [1:0] row_index;
  word_t      col0;
  word_t      col1;
  word_t      col2;
  word_t      col3;
  logic       last_row;
  logic       degenerate;
  modport source (output valid, row_index, col0, col1, col2, col3, last_row, degenerate,
                  input ready);
  modport sink (input valid, row_index, col0, col1, col2, col3, last_row, degenerate,
                output ready);
endinterface

// ===== rtl/core/lav_cross.sv =====
// two-stage exact cross product of a unit axis and a word vector
// depends on lav_pkg
module lav_cross (
  input  logic               clk,
  input  logic               en,
  input  lav_pkg::unit_t [2:0] a,
  input  lav_pkg::word_t [2:0] b,
  output lav_pkg::vec_t  [2:0] c
);
  import lav_pkg::*;

  localparam int PX = UW + DW;

  logic signed [PX-1:0] p_r   [6];
  logic signed [PX-1:0] p_nxt [6];
  vec_t [2:0] c_r;
  vec_t [2:0] c_nxt;

  always_comb begin
    p_nxt[0] = PX'($signed(a[1])) * PX'($signed(b[2]));
    p_nxt[1] = PX'($signed(a[2])) * PX'($signed(b[1]));
    p_nxt[2] = PX'($signed(a[2])) * PX'($signed(b[0]));
    p_nxt[3] = PX'($signed(a[0])) * PX'($signed(b[2]));
    p_nxt[4] = PX'($signed(a[0])) * PX'($signed(b[1]));
    p_nxt[5] = PX'($signed(a[1])) * PX'($signed(b[0]));
  end

  always_comb begin
    c_nxt[0] = VW'(p_r[0]) - VW'(p_r[1]);
    c_nxt[1] = VW'(p_r[2]) - VW'(p_r[3]);
    c_nxt[2] = VW'(p_r[4]) - VW'(p_r[5]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= p_nxt;
      c_r <= c_nxt;
    end
  end

  assign c = c_r;

endmodule

// ===== rtl/core/lav_norm.sv =====
// pipelined vector normalizer: align, square sum, digit-serial sqrt stages,
// restoring divide stages; depends on lav_pkg
module lav_norm (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_v,
  input  lav_pkg::vec_t  [2:0] in_vec,
  input  lav_pkg::side_t       in_side,
  output logic                 out_v,
  output lav_pkg::unit_t [2:0] out_unit,
  output logic                 out_nz,
  output lav_pkg::side_t       out_side
);
  import lav_pkg::*;

  localparam int SQW = 2 * NB + 4;
  localparam int NSQ = SQW / 2;
  localparam int NW  = NB + QB + 1;
  localparam int LW  = NB + 1;
  localparam int DVW = LW + 1;

  typedef struct packed {
    logic [2:0] neg;
    logic       nz;
    side_t      side;
  } tag_t;

  // magnitude and alignment
  logic             sh_v_r [NSH+1];
  logic [2:0][MW-1:0] sh_m_r [NSH+1];
  tag_t             sh_t_r [NSH+1];
  logic [2:0][MW-1:0] abs_nxt;
  tag_t             abs_t_nxt;

  always_comb begin
    abs_t_nxt.side = in_side;
    for (int i = 0; i < 3; i++) begin
      abs_t_nxt.neg[i] = in_vec[i][VW-1];
      abs_nxt[i] = in_vec[i][VW-1] ? MW'(-in_vec[i]) : MW'(in_vec[i]);
    end
    abs_t_nxt.nz = |(abs_nxt[0] | abs_nxt[1] | abs_nxt[2]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sh_v_r[0] <= 1'b0;
    end else if (en) begin
      sh_v_r[0] <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sh_m_r[0] <= abs_nxt;
      sh_t_r[0] <= abs_t_nxt;
    end
  end

  // move the leading one of the largest magnitude to the top bit
  for (genvar k = 0; k < NSH; k++) begin : g_sh
    localparam int SH = 1 << (NSH - 1 - k);
    logic [MW-1:0]      orv;
    logic [2:0][MW-1:0] m_nxt;

    always_comb begin
      orv = sh_m_r[k][0] | sh_m_r[k][1] | sh_m_r[k][2];
      for (int i = 0; i < 3; i++) begin
        m_nxt[i] = (orv[MW-1 -: SH] == '0) ? (sh_m_r[k][i] << SH) : sh_m_r[k][i];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sh_v_r[k+1] <= 1'b0;
      end else if (en) begin
        sh_v_r[k+1] <= sh_v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sh_m_r[k+1] <= m_nxt;
        sh_t_r[k+1] <= sh_t_r[k];
      end
    end
  end

  // squares; top bits give the largest component in [2^29, 2^30)
  logic                 q_v_r;
  logic [2:0][NB-1:0]   q_n_r;
  logic [2:0][2*NB-1:0] q_sq_r;
  tag_t                 q_t_r;
  logic [2:0][NB-1:0]   n_c;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      n_c[i] = sh_m_r[NSH][i][MW-1 -: NB];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_v_r <= 1'b0;
    end else if (en) begin
      q_v_r <= sh_v_r[NSH];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        q_sq_r[i] <= (2*NB)'(n_c[i]) * (2*NB)'(n_c[i]);
      end
      q_n_r <= n_c;
      q_t_r <= sh_t_r[NSH];
    end
  end

  // square root, one result bit per stage
  logic               sq_v_r   [NSQ+1];
  logic [SQW-1:0]     sq_rem_r [NSQ+1];
  logic [SQW-1:0]     sq_res_r [NSQ+1];
  logic [2:0][NB-1:0] sq_n_r   [NSQ+1];
  tag_t               sq_t_r   [NSQ+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_v_r[0] <= 1'b0;
    end else if (en) begin
      sq_v_r[0] <= q_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_rem_r[0] <= SQW'(q_sq_r[0]) + SQW'(q_sq_r[1]) + SQW'(q_sq_r[2]);
      sq_res_r[0] <= '0;
      sq_n_r[0]   <= q_n_r;
      sq_t_r[0]   <= q_t_r;
    end
  end

  for (genvar t = 0; t < NSQ; t++) begin : g_sqrt
    localparam logic [SQW-1:0] BIT = SQW'(1) << (SQW - 2 - 2 * t);
    logic [SQW-1:0] trial;
    logic           ge;

    always_comb begin
      trial = sq_res_r[t] + BIT;
      ge    = (sq_rem_r[t] >= trial);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_v_r[t+1] <= 1'b0;
      end else if (en) begin
        sq_v_r[t+1] <= sq_v_r[t];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_rem_r[t+1] <= ge ? (sq_rem_r[t] - trial) : sq_rem_r[t];
        sq_res_r[t+1] <= ge ? ((sq_res_r[t] >> 1) + BIT) : (sq_res_r[t] >> 1);
        sq_n_r[t+1]   <= sq_n_r[t];
        sq_t_r[t+1]   <= sq_t_r[t];
      end
    end
  end

  // divide (n * 2^(FRAC_BITS+1) + len) by 2*len, one quotient bit per stage
  logic                dv_v_r   [QB+1];
  logic [DVW-1:0]      dv_d_r   [QB+1];
  logic [2:0][DVW-1:0] dv_rem_r [QB+1];
  logic [2:0][QB-1:0]  dv_low_r [QB+1];
  logic [2:0][QB-1:0]  dv_q_r   [QB+1];
  tag_t                dv_t_r   [QB+1];
  logic [LW-1:0]       len_c;
  logic [2:0][NW-1:0]  num_c;

  always_comb begin
    len_c = sq_res_r[NSQ][LW-1:0];
    for (int i = 0; i < 3; i++) begin
      num_c[i] = (NW'(sq_n_r[NSQ][i]) << QB) + NW'(len_c);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_v_r[0] <= 1'b0;
    end else if (en) begin
      dv_v_r[0] <= sq_v_r[NSQ];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_d_r[0] <= {len_c, 1'b0};
      for (int i = 0; i < 3; i++) begin
        dv_rem_r[0][i] <= DVW'(num_c[i][NW-1:QB]);
        dv_low_r[0][i] <= num_c[i][QB-1:0];
      end
      dv_q_r[0] <= '0;
      dv_t_r[0] <= sq_t_r[NSQ];
    end
  end

  for (genvar k = 0; k < QB; k++) begin : g_div
    logic [2:0][DVW:0]   r2;
    logic [2:0]          ge;
    logic [2:0][DVW-1:0] rem_nxt;

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        r2[i]      = {dv_rem_r[k][i], dv_low_r[k][i][QB-1]};
        ge[i]      = (r2[i] >= {1'b0, dv_d_r[k]});
        rem_nxt[i] = ge[i] ? DVW'(r2[i] - {1'b0, dv_d_r[k]}) : DVW'(r2[i]);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[k+1] <= 1'b0;
      end else if (en) begin
        dv_v_r[k+1] <= dv_v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_d_r[k+1]   <= dv_d_r[k];
        dv_rem_r[k+1] <= rem_nxt;
        for (int i = 0; i < 3; i++) begin
          dv_low_r[k+1][i] <= dv_low_r[k][i] << 1;
          dv_q_r[k+1][i]   <= {dv_q_r[k][i][QB-2:0], ge[i]};
        end
        dv_t_r[k+1] <= dv_t_r[k];
      end
    end
  end

  // restore the signs
  logic        fin_v_r;
  unit_t [2:0] fin_u_r;
  tag_t        fin_t_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_v_r <= 1'b0;
    end else if (en) begin
      fin_v_r <= dv_v_r[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        fin_u_r[i] <= dv_t_r[QB].neg[i] ? -UW'(dv_q_r[QB][i]) : UW'(dv_q_r[QB][i]);
      end
      fin_t_r <= dv_t_r[QB];
    end
  end

  assign out_v    = fin_v_r;
  assign out_unit = fin_u_r;
  assign out_nz   = fin_t_r.nz;
  assign out_side = fin_t_r.side;

endmodule

// ===== rtl/core/lav_mat.sv =====
// matrix back end: true up axis, dot products with eye, rounding, saturation
// depends on lav_pkg and lav_cross
module lav_mat (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_v,
  input  lav_pkg::unit_t [2:0] in_s,
  input  logic                 in_nz,
  input  lav_pkg::side_t       in_side,
  output logic                 out_v,
  output lav_pkg::mat_t        out_mat
);
  import lav_pkg::*;

  localparam int PW  = UW + 1 + DW;
  localparam int DTW = PW + 2;
  localparam logic signed [DTW-1:0] WMAX = DTW'(2147483647);
  localparam logic signed [DTW-1:0] WMIN = -WMAX - DTW'(1);

  typedef struct packed {
    unit_t [2:0] s;
    unit_t [2:0] f;
    word_t [2:0] eye;
    logic        ok;
  } mtag_t;

  function automatic logic signed [DTW-1:0] rnd_shr(input logic signed [DTW-1:0] x);
    logic [DTW-1:0] m;
    m = x[DTW-1] ? DTW'(-x) : DTW'(x);
    m = (m + (DTW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    return x[DTW-1] ? -$signed(m) : $signed(m);
  endfunction

  function automatic word_t sat_w(input logic signed [DTW-1:0] x);
    word_t r;
    if (x > WMAX) begin
      r = DW'(WMAX);
    end else if (x < WMIN) begin
      r = DW'(WMIN);
    end else begin
      r = DW'(x);
    end
    return r;
  endfunction

  mtag_t       tag_c;
  word_t [2:0] fw;
  vec_t  [2:0] c_vec;

  always_comb begin
    tag_c.s   = in_s;
    tag_c.f   = in_side.f;
    tag_c.eye = in_side.eye;
    tag_c.ok  = in_side.ok && in_nz;
    for (int i = 0; i < 3; i++) begin
      fw[i] = DW'(in_side.f[i]);
    end
  end

  lav_cross u_cross (
    .clk (clk),
    .en  (en),
    .a   (in_s),
    .b   (fw),
    .c   (c_vec)
  );

  // tags ride beside the cross product unit
  logic  c_v_r [2];
  mtag_t c_t_r [2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_v_r[0] <= 1'b0;
      c_v_r[1] <= 1'b0;
    end else if (en) begin
      c_v_r[0] <= in_v;
      c_v_r[1] <= c_v_r[0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_t_r[0] <= tag_c;
      c_t_r[1] <= c_t_r[0];
    end
  end

  // u = round(s x f)
  logic         u_v_r;
  mtag_t        u_t_r;
  uwide_t [2:0] u_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      u_v_r <= 1'b0;
    end else if (en) begin
      u_v_r <= c_v_r[1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        u_r[i] <= (UW+1)'(rnd_shr(DTW'(c_vec[i])));
      end
      u_t_r <= c_t_r[1];
    end
  end

  // products with eye: [0] side, [1] up, [2] forward
  logic                  p_v_r;
  mtag_t                 p_t_r;
  uwide_t [2:0]          p_u_r;
  logic signed [PW-1:0]  p_r [3][3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_v_r <= 1'b0;
    end else if (en) begin
      p_v_r <= u_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        p_r[0][i] <= PW'($signed(u_t_r.s[i])) * PW'($signed(u_t_r.eye[i]));
        p_r[1][i] <= PW'($signed(u_r[i]))     * PW'($signed(u_t_r.eye[i]));
        p_r[2][i] <= PW'($signed(u_t_r.f[i])) * PW'($signed(u_t_r.eye[i]));
      end
      p_u_r <= u_r;
      p_t_r <= u_t_r;
    end
  end

  // sums
  logic                  a_v_r;
  mtag_t                 a_t_r;
  uwide_t [2:0]          a_u_r;
  logic signed [DTW-1:0] a_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (en) begin
      a_v_r <= p_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        a_r[j] <= DTW'(p_r[j][0]) + DTW'(p_r[j][1]) + DTW'(p_r[j][2]);
      end
      a_u_r <= p_u_r;
      a_t_r <= p_t_r;
    end
  end

  // drop the fraction bits
  logic                  r_v_r;
  mtag_t                 r_t_r;
  uwide_t [2:0]          r_u_r;
  logic signed [DTW-1:0] r_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r_v_r <= 1'b0;
    end else if (en) begin
      r_v_r <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        r_r[j] <= rnd_shr(a_r[j]);
      end
      r_u_r <= a_u_r;
      r_t_r <= a_t_r;
    end
  end

  // translation column, negated for the side and up rows
  logic fin_v_r;
  mat_t fin_r;
  mat_t fin_nxt;

  always_comb begin
    fin_nxt.s    = r_t_r.s;
    fin_nxt.u    = r_u_r;
    fin_nxt.f    = r_t_r.f;
    fin_nxt.t[0] = sat_w(-r_r[0]);
    fin_nxt.t[1] = sat_w(-r_r[1]);
    fin_nxt.t[2] = sat_w(r_r[2]);
    fin_nxt.ok   = r_t_r.ok;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_v_r <= 1'b0;
    end else if (en) begin
      fin_v_r <= r_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fin_r <= fin_nxt;
    end
  end

  assign out_v   = fin_v_r;
  assign out_mat = fin_r;

endmodule

// ===== rtl/core/lav_emit.sv =====
// row serializer: holds one finished matrix and hands out its four rows
// depends on lav_pkg and lav_out_if
module lav_emit (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_v,
  input  lav_pkg::mat_t in_mat,
  output logic          rdy,
  lav_out_if.source     out_ch
);
  import lav_pkg::*;

  logic       busy_r;
  logic       busy_nxt;
  logic [1:0] row_r;
  logic [1:0] row_nxt;
  mat_t       mat_r;
  logic       take;

  // a new matrix may load while the last row is being taken
  assign rdy  = !busy_r || (row_r == ROW_W && out_ch.ready);
  assign take = in_v && rdy;

  always_comb begin
    busy_nxt = busy_r;
    row_nxt  = row_r;
    if (busy_r && out_ch.ready) begin
      if (row_r == ROW_W) begin
        busy_nxt = 1'b0;
      end else begin
        row_nxt = row_r + 2'd1;
      end
    end
    if (take) begin
      busy_nxt = 1'b1;
      row_nxt  = ROW_S;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      row_r  <= ROW_S;
    end else begin
      busy_r <= busy_nxt;
      row_r  <= row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      mat_r <= in_mat;
    end
  end

  always_comb begin
    out_ch.valid      = busy_r;
    out_ch.row_index  = row_r;
    out_ch.last_row   = (row_r == ROW_W);
    out_ch.degenerate = !mat_r.ok;
    out_ch.col0 = '0;
    out_ch.col1 = '0;
    out_ch.col2 = '0;
    out_ch.col3 = '0;
    if (mat_r.ok) begin
      case (row_r)
        ROW_S: begin
          out_ch.col0 = DW'(mat_r.s[0]);
          out_ch.col1 = DW'(mat_r.s[1]);
          out_ch.col2 = DW'(mat_r.s[2]);
          out_ch.col3 = mat_r.t[0];
        end
        ROW_U: begin
          out_ch.col0 = DW'(mat_r.u[0]);
          out_ch.col1 = DW'(mat_r.u[1]);
          out_ch.col2 = DW'(mat_r.u[2]);
          out_ch.col3 = mat_r.t[1];
        end
        ROW_F: begin
          out_ch.col0 = DW'(-mat_r.f[0]);
          out_ch.col1 = DW'(-mat_r.f[1]);
          out_ch.col2 = DW'(-mat_r.f[2]);
          out_ch.col3 = mat_r.t[2];
        end
        ROW_W: begin
          out_ch.col3 = ONE_Q;
        end
        default: begin
          out_ch.col3 = '0;
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/look_at_view_matrix.sv =====
// look-at view matrix builder, top level
// depends on lav_pkg, lav_if, lav_norm, lav_cross, lav_mat, lav_emit and the defines header
`include "look_at_view_matrix_defines.svh"

// Takes eye, target and up vectors in signed Q16.16 and returns the 4x4 view
// matrix as four row results, rows 0 to 3 in order, last_row set on row 3.
// Forward and side axes are each normalized by a fully pipelined unit
// (alignment, square sum, one sqrt bit and one quotient bit per stage), so a
// request can enter every cycle while the pipeline is not held; sustained
// throughput is limited by the four rows sharing the single result channel. A
// zero forward axis or an up vector parallel to it gives four all-zero rows with
// degenerate set. The whole pipeline advances together and holds when the row
// serializer is full.
module look_at_view_matrix (
  input logic       clk,
  input logic       rst_n,
  lav_in_if.sink    in_ch,
  lav_out_if.source out_ch
);
  import lav_pkg::*;

  logic en;
  logic emit_rdy;
  logic mat_v;
  mat_t mat;

  // difference stage
  logic       d_v_r;
  vec_t [2:0] d_r;
  side_t      d_side_r;
  side_t      d_side_nxt;

  assign in_ch.ready = en;

  always_comb begin
    d_side_nxt.eye[0] = in_ch.eye_x;
    d_side_nxt.eye[1] = in_ch.eye_y;
    d_side_nxt.eye[2] = in_ch.eye_z;
    d_side_nxt.up[0]  = in_ch.up_x;
    d_side_nxt.up[1]  = in_ch.up_y;
    d_side_nxt.up[2]  = in_ch.up_z;
    d_side_nxt.f      = '0;
    d_side_nxt.ok     = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_v_r <= 1'b0;
    end else if (en) begin
      d_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r[0]   <= VW'(in_ch.target_x) - VW'(in_ch.eye_x);
      d_r[1]   <= VW'(in_ch.target_y) - VW'(in_ch.eye_y);
      d_r[2]   <= VW'(in_ch.target_z) - VW'(in_ch.eye_z);
      d_side_r <= d_side_nxt;
    end
  end

  // forward axis
  logic        f_v;
  unit_t [2:0] f_unit;
  logic        f_nz;
  side_t       f_side;
  side_t       f_side_m;

  lav_norm u_norm_f (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_v     (d_v_r),
    .in_vec   (d_r),
    .in_side  (d_side_r),
    .out_v    (f_v),
    .out_unit (f_unit),
    .out_nz   (f_nz),
    .out_side (f_side)
  );

  always_comb begin
    f_side_m    = f_side;
    f_side_m.f  = f_unit;
    f_side_m.ok = f_nz;
  end

  // f x up
  vec_t [2:0] x_vec;
  logic       x_v_r    [2];
  side_t      x_side_r [2];

  lav_cross u_cross_side (
    .clk (clk),
    .en  (en),
    .a   (f_unit),
    .b   (f_side.up),
    .c   (x_vec)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_v_r[0] <= 1'b0;
      x_v_r[1] <= 1'b0;
    end else if (en) begin
      x_v_r[0] <= f_v;
      x_v_r[1] <= x_v_r[0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_side_r[0] <= f_side_m;
      x_side_r[1] <= x_side_r[0];
    end
  end

  // side axis
  logic        s_v;
  unit_t [2:0] s_unit;
  logic        s_nz;
  side_t       s_side;

  lav_norm u_norm_s (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_v     (x_v_r[1]),
    .in_vec   (x_vec),
    .in_side  (x_side_r[1]),
    .out_v    (s_v),
    .out_unit (s_unit),
    .out_nz   (s_nz),
    .out_side (s_side)
  );

  lav_mat u_mat (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_v    (s_v),
    .in_s    (s_unit),
    .in_nz   (s_nz),
    .in_side (s_side),
    .out_v   (mat_v),
    .out_mat (mat)
  );

  // the pipeline moves unless a finished matrix cannot be handed over
  assign en = !mat_v || emit_rdy;

  lav_emit u_emit (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_v   (mat_v),
    .in_mat (mat),
    .rdy    (emit_rdy),
    .out_ch (out_ch)
  );

  `LAV_ASSERT_NOW(a_degen_zero, out_ch.valid && out_ch.degenerate,
    out_ch.col0 == '0 && out_ch.col1 == '0 && out_ch.col2 == '0 && out_ch.col3 == '0,
    "degenerate row with nonzero entries")
  `LAV_ASSERT_NOW(a_last_row, out_ch.valid,
    out_ch.last_row == (out_ch.row_index == ROW_W), "last_row does not match row 3")
  `LAV_ASSERT_NEXT(a_row_step, out_ch.valid && out_ch.ready && !out_ch.last_row,
    out_ch.valid && out_ch.row_index == $past(out_ch.row_index) + 2'd1,
    "row sequence broken")
  `LAV_ASSERT_NEXT(a_tail_hold, mat_v && !en, mat_v && $stable(mat),
    "stalled matrix lost or changed")

endmodule

// ===== bench/testbench.sv =====
// self-checking bench for look_at_view_matrix: directed camera table, then random requests
// depends on lav_pkg, lav_if and the look_at_view_matrix rtl
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import lav_pkg::*;

  localparam int    CYCLE_LIMIT = 400000;
  localparam int    RAND_FIRST = 160;
  localparam int    RAND_PER_PHASE = 60;
  localparam int    DRAIN_CYCLES = 200;
  localparam word_t WMAX = 32'sh7fffffff;
  localparam word_t WMIN = 32'sh80000000;
  localparam word_t Q1 = ONE_Q;

  typedef struct packed {
    word_t [2:0] eye;
    word_t [2:0] tgt;
    word_t [2:0] up;
  } cam_t;

  typedef struct packed {
    logic [1:0] idx;
    word_t      c0, c1, c2, c3;
    logic       last;
    logic       degen;
  } row_t;

  typedef struct {
    cam_t             cam;
    bit               typed;
    bit               degen;
    word_t [3:0][3:0] m;
  } dir_t;

  typedef longint vec3_t[3];

  logic clk = 0;
  logic rst_n = 0;
  lav_in_if  in_ch();
  lav_out_if out_ch();

  look_at_view_matrix u_dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  row_t   rows_pending[$];
  int     errors = 0;
  int     rows_seen = 0;
  int     degen_seen = 0;
  int     sent = 0;
  int     cyc = 0;
  int     idle_pct = 0;
  int     stall_pct = 0;
  bit     hold_req = 0;
  bit     hold_done = 0;
  int     hold_cnt = 0;

  // ---------------- predictor ----------------
  function automatic longint round_shift(longint v);
    longint unsigned m;
    m = v < 0 ? -v : v;
    m = (m + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    return v < 0 ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic bit normalize(input vec3_t v, output vec3_t u);
    longint unsigned m[3];
    longint unsigned big, sum, len, num;
    big = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = v[i] < 0 ? -v[i] : v[i];
      if (m[i] > big) big = m[i];
    end
    u = '{0, 0, 0};
    if (big == 0) return 0;
    while (big >= (64'd1 << 30)) begin
      for (int i = 0; i < 3; i++) m[i] >>= 1;
      big >>= 1;
    end
    while (big < (64'd1 << 29)) begin
      for (int i = 0; i < 3; i++) m[i] <<= 1;
      big <<= 1;
    end
    sum = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
    len = int_sqrt(sum);
    for (int i = 0; i < 3; i++) begin
      num = (m[i] << FRAC_BITS) * 2 + len;
      u[i] = v[i] < 0 ? -longint'(num / (len * 2)) : longint'(num / (len * 2));
    end
    return 1;
  endfunction

  function automatic void cross_vec(input vec3_t a, input vec3_t b, output vec3_t c);
    c[0] = a[1] * b[2] - a[2] * b[1];
    c[1] = a[2] * b[0] - a[0] * b[2];
    c[2] = a[0] * b[1] - a[1] * b[0];
  endfunction

  function automatic word_t sat_word(longint v);
    if (v > 64'sd2147483647) return WMAX;
    if (v < -64'sd2147483648) return WMIN;
    return word_t'(v);
  endfunction

  function automatic longint dot_eye(vec3_t a, vec3_t e);
    return round_shift(a[0] * e[0] + a[1] * e[1] + a[2] * e[2]);
  endfunction

  function automatic void predict_view(cam_t c);
    vec3_t eye, upv, d, f, x, s, u;
    word_t [3:0][3:0] m;
    bit ok;
    for (int i = 0; i < 3; i++) begin
      eye[i] = c.eye[i];
      upv[i] = c.up[i];
      d[i] = longint'(c.tgt[i]) - longint'(c.eye[i]);
    end
    m = '0;
    ok = normalize(d, f);
    if (ok) begin
      cross_vec(f, upv, x);
      ok = normalize(x, s);
    end
    if (ok) begin
      cross_vec(s, f, x);
      for (int i = 0; i < 3; i++) begin
        u[i] = round_shift(x[i]);
        m[0][i] = word_t'(s[i]);
        m[1][i] = word_t'(u[i]);
        m[2][i] = word_t'(-f[i]);
      end
      m[0][3] = sat_word(-dot_eye(s, eye));
      m[1][3] = sat_word(-dot_eye(u, eye));
      m[2][3] = sat_word(dot_eye(f, eye));
      m[3][3] = Q1;
    end
    push_rows(m, !ok);
  endfunction

  function automatic void push_rows(word_t [3:0][3:0] m, bit degen);
    row_t r;
    for (int k = 0; k < 4; k++) begin
      r.idx = 2'(k);
      r.c0 = m[k][0];
      r.c1 = m[k][1];
      r.c2 = m[k][2];
      r.c3 = m[k][3];
      r.last = (k == 3);
      r.degen = degen;
      rows_pending.push_back(r);
    end
  endfunction

  // ---------------- result checking ----------------
  function automatic void check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    row_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      rows_seen++;
      if (rows_pending.size() == 0) begin
        $error("row result with no request outstanding");
        errors++;
      end else begin
        e = rows_pending.pop_front();
        if (e.degen) degen_seen++;
        check_field("row_index", e.idx, out_ch.row_index);
        check_field("col0", e.c0, out_ch.col0);
        check_field("col1", e.c1, out_ch.col1);
        check_field("col2", e.c2, out_ch.col2);
        check_field("col3", e.c3, out_ch.col3);
        check_field("last_row", e.last, out_ch.last_row);
        check_field("degenerate", e.degen, out_ch.degenerate);
      end
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_req && !hold_done) begin
      hold_done <= 1;
      hold_cnt <= 600;
      out_ch.ready <= 0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_ch.ready <= 0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc > CYCLE_LIMIT) begin
      $display("[look_at_view_matrix] ERROR");
      $finish;
    end
  end

  // ---------------- stimulus ----------------
  task automatic send_cam(cam_t c, bit typed, bit degen, word_t [3:0][3:0] m);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 0;
      @(posedge clk);
    end
    in_ch.valid <= 1;
    {in_ch.eye_x, in_ch.eye_y, in_ch.eye_z} <= {c.eye[0], c.eye[1], c.eye[2]};
    {in_ch.target_x, in_ch.target_y, in_ch.target_z} <= {c.tgt[0], c.tgt[1], c.tgt[2]};
    {in_ch.up_x, in_ch.up_y, in_ch.up_z} <= {c.up[0], c.up[1], c.up[2]};
    do @(posedge clk); while (!in_ch.ready);
    if (typed) push_rows(m, degen);
    else predict_view(c);
    sent++;
  endtask

  function automatic word_t rand_word(int mode);
    word_t w;
    w = $urandom;
    if (mode >= 2) w = w >>> $urandom_range(4, 24);
    return w;
  endfunction

  function automatic cam_t rand_cam();
    cam_t c;
    int mode;
    mode = $urandom_range(9);
    for (int i = 0; i < 3; i++) begin
      c.eye[i] = rand_word(mode);
      c.tgt[i] = rand_word(mode);
      c.up[i] = rand_word(mode);
    end
    if (mode == 8) c.tgt = c.eye;
    if (mode == 9) begin
      // up along the forward axis
      for (int i = 0; i < 3; i++) begin
        c.eye[i] = word_t'($signed($urandom) >>> 8);
        c.tgt[i] = word_t'($signed($urandom) >>> 8);
        c.up[i] = c.tgt[i] - c.eye[i];
      end
    end
    return c;
  endfunction

  dir_t dir_tab[$];

  function automatic dir_t mk(word_t ex, word_t ey, word_t ez, word_t tx, word_t ty, word_t tz,
                              word_t ux, word_t uy, word_t uz, bit typed, bit degen);
    dir_t d;
    d.cam.eye = {ez, ey, ex};
    d.cam.tgt = {tz, ty, tx};
    d.cam.up = {uz, uy, ux};
    d.typed = typed;
    d.degen = degen;
    d.m = '0;
    return d;
  endfunction

  initial begin
    dir_t d;
    word_t [3:0][3:0] none;
    none = '0;
    in_ch.valid = 0;
    {in_ch.eye_x, in_ch.eye_y, in_ch.eye_z} = '0;
    {in_ch.target_x, in_ch.target_y, in_ch.target_z} = '0;
    {in_ch.up_x, in_ch.up_y, in_ch.up_z} = '0;

    // camera at origin looking down -z with +y up gives the identity
    d = mk(0, 0, 0, 0, 0, -Q1, 0, Q1, 0, 1, 0);
    d.m[0][0] = Q1; d.m[1][1] = Q1; d.m[2][2] = Q1; d.m[3][3] = Q1;
    dir_tab.push_back(d);
    // target on the eye
    dir_tab.push_back(mk(5 * Q1, -3 * Q1, Q1, 5 * Q1, -3 * Q1, Q1, 0, Q1, 0, 1, 1));
    dir_tab.push_back(mk(WMAX, WMIN, WMAX, WMAX, WMIN, WMAX, WMAX, WMAX, WMIN, 1, 1));
    // zero up vector
    dir_tab.push_back(mk(0, 0, 0, Q1, 2 * Q1, 3 * Q1, 0, 0, 0, 1, 1));
    // up parallel and antiparallel to forward
    dir_tab.push_back(mk(0, 0, 0, 0, 0, 5 * Q1, 0, 0, Q1, 1, 1));
    dir_tab.push_back(mk(Q1, Q1, Q1, 3 * Q1, 3 * Q1, 3 * Q1, -Q1, -Q1, -Q1, 1, 1));
    // field extremes and saturated translations
    dir_tab.push_back(mk(WMAX, WMAX, WMAX, WMIN, WMIN, WMIN, 0, Q1, 0, 0, 0));
    dir_tab.push_back(mk(WMIN, WMIN, WMIN, WMAX, WMAX, WMAX, WMAX, WMIN, WMAX, 0, 0));
    dir_tab.push_back(mk(WMAX, WMAX, WMAX, 0, 0, 0, WMIN, WMAX, 0, 0, 0));
    dir_tab.push_back(mk(WMIN, WMIN, WMIN, 0, 0, 0, 0, 0, WMIN, 0, 0));
    dir_tab.push_back(mk(WMIN, WMAX, WMIN, WMAX, WMIN, WMAX, WMIN, WMIN, WMIN, 0, 0));
    // raw lsb up vector and lsb forward
    dir_tab.push_back(mk(0, 0, 0, 0, 0, -Q1, 1, 0, 0, 0, 0));
    dir_tab.push_back(mk(-1, -1, -1, 0, 0, -1, -1, 1, -1, 0, 0));
    dir_tab.push_back(mk(7 * Q1, 2 * Q1, -4 * Q1, -Q1 / 2, 9 * Q1, 3, Q1, -Q1, Q1 / 4, 0, 0));

    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    foreach (dir_tab[i]) send_cam(dir_tab[i].cam, dir_tab[i].typed, dir_tab[i].degen,
                                  dir_tab[i].m);

    for (int ph = 0; ph < 4; ph++) begin
      // sender waits for every outstanding row before each phase
      in_ch.valid <= 0;
      wait (rows_pending.size() == 0);
      @(posedge clk);
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  hold_req = 1; end
        1: begin idle_pct = 82; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 82; end
        default: begin idle_pct = 35; stall_pct = 35; end
      endcase
      // the first phase offers more requests than the pipeline holds
      for (int n = 0; n < (ph == 0 ? RAND_FIRST : RAND_PER_PHASE); n++) begin
        send_cam(rand_cam(), 0, 0, none);
      end
    end
    in_ch.valid <= 0;

    wait (rows_pending.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("sent %0d camera requests, checked %0d rows (%0d degenerate)",
             sent, rows_seen, degen_seen);
    $display("phases: free flow with long output hold, sender gaps, output stalls, mixed");
    if (errors == 0 && rows_pending.size() == 0) begin
      $display("[look_at_view_matrix] OK");
    end else begin
      $display("[look_at_view_matrix] ERROR");
    end
    $finish;
  end

endmodule
